// File: design/tpp_pkg.sv
`timescale 1ns / 1ps

package tpp_pkg;

  // Image and fixed-point geometry.
  localparam int unsigned MAX_SIDE  = 4096;
  localparam int unsigned FRAC_BITS = 20;

  // Field widths.
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned STEP_W   = 21;
  localparam int unsigned ORIGIN_W = 23;
  localparam int unsigned PIX_W    = 16;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = ORIGIN_W;

  // Datapath widths. A coordinate is index * step - origin, which needs two
  // bits beyond the product to hold the sign and the +/- offset.
  localparam int unsigned PROD_W  = IDX_W + STEP_W;
  localparam int unsigned COORD_W = PROD_W + 2;
  localparam int unsigned ABS_W   = COORD_W - 1;

  // Pipeline depth from acceptance to the output register.
  localparam int unsigned NUM_STAGES = 6;

  // Geometric constants, rounded half up at FRAC_BITS fraction bits.
  localparam longint ONE_FX  = longint'(1) << FRAC_BITS;
  localparam longint K_RAD   = (16 * ONE_FX + 50) / 100;
  localparam longint K_TRANS = (22 * ONE_FX + 50) / 100;
  localparam longint K_SQ    = (45 * ONE_FX + 50) / 100;
  localparam longint K_SQ_IN = (4365 * ONE_FX + 5000) / 10000;
  localparam longint K_RADIN = (112 * ONE_FX + 500) / 1000;
  localparam longint K_DIAM  = (144 * ONE_FX + 500) / 1000;

  // Disc tests only need magnitudes below the outer radius.
  localparam int unsigned SQR_W   = $clog2(K_RAD + 1);
  localparam int unsigned SQ_W    = 2 * SQR_W;
  localparam int unsigned SUMSQ_W = SQ_W + 1;

  localparam logic [COORD_W-1:0] TRANS_C  = COORD_W'(K_TRANS);
  localparam logic [ABS_W-1:0]   RAD_A    = ABS_W'(K_RAD);
  localparam logic [ABS_W-1:0]   RADIN_A  = ABS_W'(K_RADIN);
  localparam logic [ABS_W-1:0]   SQ_A     = ABS_W'(K_SQ);
  localparam logic [ABS_W-1:0]   SQIN_A   = ABS_W'(K_SQ_IN);
  localparam logic [ABS_W:0]     DIAM_A   = (ABS_W + 1)'(K_DIAM);
  localparam logic [SUMSQ_W-1:0] RAD_SQ   = SUMSQ_W'(K_RAD * K_RAD);
  localparam logic [SUMSQ_W-1:0] RADIN_SQ = SUMSQ_W'(K_RADIN * K_RADIN);

  // Output levels, unsigned Q2.14.
  localparam logic [PIX_W-1:0] V_I_HI    = 16'd24576;
  localparam logic [PIX_W-1:0] V_I_MID   = 16'd17203;
  localparam logic [PIX_W-1:0] V_II_LO   = 16'd3277;
  localparam logic [PIX_W-1:0] V_II_HI   = 16'd32768;
  localparam logic [PIX_W-1:0] V_III_LO  = 16'd8192;
  localparam logic [PIX_W-1:0] V_III_HI  = 16'd16384;
  localparam logic [PIX_W-1:0] V_III_MID = 16'd18022;

  // Phantom variants.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_DENSITY      = 2'd0,
    FUNC_TRANSMISSION = 2'd1,
    FUNC_ATTENUATION  = 2'd2
  } func_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COORD_STEP   = 1'b0,
    CFG_COORD_ORIGIN = 1'b1
  } cfg_reg_e;

  // Magnitudes of the plain and offset coordinates of one pixel.
  typedef struct packed {
    logic              blank;
    logic [FUNC_W-1:0] func;
    logic [ABS_W-1:0]  ax;
    logic [ABS_W-1:0]  ay;
    logic [ABS_W-1:0]  axp;
    logic [ABS_W-1:0]  axm;
    logic [ABS_W-1:0]  ayp;
    logic [ABS_W-1:0]  aym;
  } coord_t;

endpackage

// File: design/tomography_phantom_pixel_unit.sv
`timescale 1ns / 1ps

// Test phantom pixel generator. Each input beat names a pixel by row_i and
// col_i and picks a phantom variant with func_i; each output beat carries
// the pixel's attenuation in unsigned Q2.14 on pixel_value_o.
// Both channels use valid and stall: a beat moves at a rising edge where
// valid is high and stall is low.
// The datapath is a six-stage pipeline (scale, center, magnitude, box
// tests, squares, disc tests and selection), and one pixel is taken every
// cycle while stall_o is low.
// When stall_i holds a result, the stages behind it keep moving into any
// empty slots; stall_o rises only once every stage holds a pixel.
// The config channel (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_wdata_i)
// writes coord_step (index 0) and coord_origin (index 1); it is always
// ready and must only be used while the pipeline is empty.
// Reset empties the pipeline and loads the default step and origin.
module tomography_phantom_pixel_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            stall_o,
  input  logic [tpp_pkg::FUNC_W-1:0]      func_i,
  input  logic [tpp_pkg::IDX_W-1:0]       row_i,
  input  logic [tpp_pkg::IDX_W-1:0]       col_i,
  output logic                            valid_o,
  input  logic                            stall_i,
  output logic [tpp_pkg::PIX_W-1:0]       pixel_value_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tpp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tpp_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int unsigned NS = tpp_pkg::NUM_STAGES;

  // Configuration registers.
  logic [tpp_pkg::STEP_W-1:0]   coord_step_d, coord_step_q;
  logic [tpp_pkg::ORIGIN_W-1:0] coord_origin_d, coord_origin_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    coord_step_d   = coord_step_q;
    coord_origin_d = coord_origin_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        tpp_pkg::CFG_COORD_STEP: begin
          coord_step_d = cfg_wdata_i[tpp_pkg::STEP_W-1:0];
        end
        tpp_pkg::CFG_COORD_ORIGIN: begin
          coord_origin_d = cfg_wdata_i;
        end
        default: begin
          coord_step_d = coord_step_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_step_q   <= 21'd1382;
      coord_origin_q <= 23'd741455;
    end else begin
      coord_step_q   <= coord_step_d;
      coord_origin_q <= coord_origin_d;
    end
  end

  // Pipeline control: a stage loads when it is empty or its successor moves.
  logic [NS-1:0] v_d, v_q, en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || !stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[0] = en[0] ? valid_i : v_q[0];
    for (int k = 1; k < NS; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign stall_o = !en[0];
  assign valid_o = v_q[NS-1];

  // Datapath.
  tpp_pkg::coord_t coord;

  tpp_coord u_coord (
    .clk_i          (clk_i),
    .en_i           (en[2:0]),
    .func_i         (func_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .coord_step_i   (coord_step_q),
    .coord_origin_i (coord_origin_q),
    .coord_o        (coord)
  );

  tpp_region u_region (
    .clk_i         (clk_i),
    .en_i          (en[5:3]),
    .coord_i       (coord),
    .pixel_value_o (pixel_value_o)
  );

  // Checks.
  logic in_beat, out_beat;

  assign in_beat  = valid_i && !stall_o;
  assign out_beat = valid_o && !stall_i;

  // Input stalls only when every stage holds a pixel.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (&v_q))
    else $error("input stalled while the pipeline has an empty stage");

  // Pixels in flight change only by accepted and delivered beats.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |->
      ($countones(v_q) == $countones($past(v_q)) + int'($past(in_beat)) -
                          int'($past(out_beat))))
    else $error("pixel lost or duplicated in the pipeline");

  // Every delivered value is one of the phantom levels.
  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (pixel_value_o == '0) ||
                (pixel_value_o == tpp_pkg::V_I_HI) ||
                (pixel_value_o == tpp_pkg::V_I_MID) ||
                (pixel_value_o == tpp_pkg::V_II_LO) ||
                (pixel_value_o == tpp_pkg::V_II_HI) ||
                (pixel_value_o == tpp_pkg::V_III_LO) ||
                (pixel_value_o == tpp_pkg::V_III_HI) ||
                (pixel_value_o == tpp_pkg::V_III_MID))
    else $error("pixel value is not a phantom level");

endmodule

// File: design/tpp_coord.sv
`timescale 1ns / 1ps

module tpp_coord (
  input  logic                          clk_i,
  input  logic [2:0]                    en_i,
  input  logic [tpp_pkg::FUNC_W-1:0]    func_i,
  input  logic [tpp_pkg::IDX_W-1:0]     row_i,
  input  logic [tpp_pkg::IDX_W-1:0]     col_i,
  input  logic [tpp_pkg::STEP_W-1:0]    coord_step_i,
  input  logic [tpp_pkg::ORIGIN_W-1:0]  coord_origin_i,
  output tpp_pkg::coord_t               coord_o
);

  localparam int unsigned PW = tpp_pkg::PROD_W;
  localparam int unsigned CW = tpp_pkg::COORD_W;
  localparam int unsigned AW = tpp_pkg::ABS_W;

  function automatic logic [AW-1:0] mag(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] neg;
    neg = -v;
    return v[CW-1] ? neg[AW-1:0] : v[AW-1:0];
  endfunction

  // Stage 1: scale the indices by the step.
  logic [PW-1:0]              px_d, py_d, px_q, py_q;
  logic [tpp_pkg::FUNC_W-1:0] s1_func_q;
  logic                       blank_d, s1_blank_q;

  assign px_d = PW'(row_i) * PW'(coord_step_i);
  assign py_d = PW'(col_i) * PW'(coord_step_i);

  // An unused variant or an index beyond the image gives a zero pixel.
  assign blank_d = (func_i != tpp_pkg::FUNC_DENSITY) &&
                   (func_i != tpp_pkg::FUNC_TRANSMISSION) &&
                   (func_i != tpp_pkg::FUNC_ATTENUATION) ||
                   (32'(row_i) >= tpp_pkg::MAX_SIDE) ||
                   (32'(col_i) >= tpp_pkg::MAX_SIDE);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      px_q       <= px_d;
      py_q       <= py_d;
      s1_func_q  <= func_i;
      s1_blank_q <= blank_d;
    end
  end

  // Stage 2: shift to the centered origin.
  logic signed [CW-1:0]       x_d, y_d, x_q, y_q;
  logic [tpp_pkg::FUNC_W-1:0] s2_func_q;
  logic                       s2_blank_q;

  assign x_d = $signed({2'b00, px_q}) - $signed(CW'(coord_origin_i));
  assign y_d = $signed({2'b00, py_q}) - $signed(CW'(coord_origin_i));

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      x_q        <= x_d;
      y_q        <= y_d;
      s2_func_q  <= s1_func_q;
      s2_blank_q <= s1_blank_q;
    end
  end

  // Stage 3: magnitudes of the plain and offset coordinates.
  tpp_pkg::coord_t      coord_d, coord_q;
  logic signed [CW-1:0] xp, xm, yp, ym;

  always_comb begin
    xp            = x_q + $signed(tpp_pkg::TRANS_C);
    xm            = x_q - $signed(tpp_pkg::TRANS_C);
    yp            = y_q + $signed(tpp_pkg::TRANS_C);
    ym            = y_q - $signed(tpp_pkg::TRANS_C);
    coord_d.blank = s2_blank_q;
    coord_d.func  = s2_func_q;
    coord_d.ax    = mag(x_q);
    coord_d.ay    = mag(y_q);
    coord_d.axp   = mag(xp);
    coord_d.axm   = mag(xm);
    coord_d.ayp   = mag(yp);
    coord_d.aym   = mag(ym);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      coord_q <= coord_d;
    end
  end

  assign coord_o = coord_q;

endmodule

// File: design/tpp_region.sv
`timescale 1ns / 1ps

module tpp_region (
  input  logic                       clk_i,
  input  logic [2:0]                 en_i,
  input  tpp_pkg::coord_t            coord_i,
  output logic [tpp_pkg::PIX_W-1:0]  pixel_value_o
);

  localparam int unsigned AW  = tpp_pkg::ABS_W;
  localparam int unsigned RW  = tpp_pkg::SQR_W;
  localparam int unsigned QW  = tpp_pkg::SQ_W;
  localparam int unsigned SW  = tpp_pkg::SUMSQ_W;

  typedef struct packed {
    logic                       blank;
    logic [tpp_pkg::FUNC_W-1:0] func;
    logic                       outer;
    logic                       box_ul;
    logic                       box_dr;
    logic                       boxin_dr;
    logic                       box_dl;
    logic                       diam;
    logic                       box_ur;
  } flags_t;

  // Saturate a magnitude to the disc range; beyond it the box test fails.
  function automatic logic [RW-1:0] clamp(input logic [AW-1:0] a);
    return (|a[AW-1:RW]) ? {RW{1'b1}} : a[RW-1:0];
  endfunction

  // Stage 4: box, diamond and outer square tests.
  flags_t        fl_d, s4_fl_q;
  logic [RW-1:0] cxp_q, cxm_q, cyp_q, cym_q;
  logic          lt_sq, eq_in;

  always_comb begin
    lt_sq = (coord_i.ax < tpp_pkg::SQ_A) && (coord_i.ay < tpp_pkg::SQ_A);
    // max(|x|,|y|) equal to the inner square side exactly does not match.
    eq_in = ((coord_i.ax == tpp_pkg::SQIN_A) && (coord_i.ay <= tpp_pkg::SQIN_A)) ||
            ((coord_i.ay == tpp_pkg::SQIN_A) && (coord_i.ax <= tpp_pkg::SQIN_A));
    fl_d.blank    = coord_i.blank;
    fl_d.func     = coord_i.func;
    fl_d.outer    = lt_sq && !eq_in;
    fl_d.box_ul   = (coord_i.axp < tpp_pkg::RAD_A) && (coord_i.ayp < tpp_pkg::RAD_A);
    fl_d.box_dr   = (coord_i.axm < tpp_pkg::RAD_A) && (coord_i.aym < tpp_pkg::RAD_A);
    fl_d.boxin_dr = (coord_i.axm < tpp_pkg::RADIN_A) && (coord_i.aym < tpp_pkg::RADIN_A);
    fl_d.box_dl   = (coord_i.axm < tpp_pkg::RAD_A) && (coord_i.ayp < tpp_pkg::RAD_A);
    fl_d.diam     = ((AW + 1)'(coord_i.axm) + (AW + 1)'(coord_i.ayp)) < tpp_pkg::DIAM_A;
    fl_d.box_ur   = (coord_i.axp < tpp_pkg::RAD_A) && (coord_i.aym < tpp_pkg::RAD_A);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s4_fl_q <= fl_d;
      cxp_q   <= clamp(coord_i.axp);
      cxm_q   <= clamp(coord_i.axm);
      cyp_q   <= clamp(coord_i.ayp);
      cym_q   <= clamp(coord_i.aym);
    end
  end

  // Stage 5: squares of the offset magnitudes.
  flags_t        s5_fl_q;
  logic [QW-1:0] sxp_q, sxm_q, syp_q, sym_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s5_fl_q <= s4_fl_q;
      sxp_q   <= QW'(cxp_q) * QW'(cxp_q);
      sxm_q   <= QW'(cxm_q) * QW'(cxm_q);
      syp_q   <= QW'(cyp_q) * QW'(cyp_q);
      sym_q   <= QW'(cym_q) * QW'(cym_q);
    end
  end

  // Stage 6: disc tests and the ordered overwrite, last match wins.
  logic [tpp_pkg::PIX_W-1:0] lo, hi, pix_d, pix_q;
  logic                      disc_in, disc_dl, disc_ur;

  always_comb begin
    case (s5_fl_q.func)
      tpp_pkg::FUNC_DENSITY: begin
        lo = '0;
        hi = tpp_pkg::V_I_HI;
      end
      tpp_pkg::FUNC_TRANSMISSION: begin
        lo = tpp_pkg::V_II_LO;
        hi = tpp_pkg::V_II_HI;
      end
      default: begin
        lo = tpp_pkg::V_III_LO;
        hi = tpp_pkg::V_III_HI;
      end
    endcase

    disc_in = s5_fl_q.boxin_dr && ((SW'(sxm_q) + SW'(sym_q)) < tpp_pkg::RADIN_SQ);
    disc_dl = s5_fl_q.box_dl && ((SW'(sxm_q) + SW'(syp_q)) < tpp_pkg::RAD_SQ);
    disc_ur = s5_fl_q.box_ur && ((SW'(sxp_q) + SW'(sym_q)) < tpp_pkg::RAD_SQ);

    pix_d = '0;
    if ((s5_fl_q.func != tpp_pkg::FUNC_DENSITY) && s5_fl_q.outer) begin
      pix_d = lo;
    end
    if (s5_fl_q.box_ul) begin
      pix_d = hi;
    end
    if (s5_fl_q.box_dr) begin
      pix_d = hi;
    end
    if (disc_in) begin
      if (s5_fl_q.func == tpp_pkg::FUNC_DENSITY) begin
        pix_d = tpp_pkg::V_I_MID;
      end else if (s5_fl_q.func == tpp_pkg::FUNC_ATTENUATION) begin
        pix_d = tpp_pkg::V_III_MID;
      end
    end
    if (disc_dl) begin
      pix_d = hi;
    end
    if (s5_fl_q.diam) begin
      pix_d = lo;
    end
    if (disc_ur) begin
      pix_d = hi;
    end
    if (s5_fl_q.blank) begin
      pix_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      pix_q <= pix_d;
    end
  end

  assign pixel_value_o = pix_q;

endmodule
